>>> src/differential_drive_odometry_unit_defines.svh
// ----------------------------------------------------------------------------
// Odometry assertion macros
// Concurrent assertion helpers for the odometry unit; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DDO_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("odometry assertion failed");
`define DDO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("odometry assertion failed");
`else
`define DDO_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define DDO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> src/ddo_pkg.sv
// ----------------------------------------------------------------------------
// Odometry package
// Widths, fixed-point constants, reciprocal multipliers, sine table and the
// command bundle between the controller and the datapath.
// ----------------------------------------------------------------------------
package ddo_pkg;

	localparam int COUNT_W       = 11;
	localparam int FRAC_BITS     = 16;
	localparam int POSITION_BITS = 48;
	localparam int LIN_W         = 16;
	localparam int ANG_W         = 19;
	localparam int INT_W         = 32;
	localparam int HEAD_INT_W    = 13;
	localparam int HEADING_W     = HEAD_INT_W + FRAC_BITS;
	localparam int HSUM_W        = HEADING_W + 2;
	localparam int DEG_W         = 9;
	localparam int SINE_W        = 10;
	localparam int TRIG_IDX_W    = 7;

	localparam int HEADING_TURN = 6283;
	localparam logic [HEADING_W-1:0] HEADING_FULL = HEADING_W'(HEADING_TURN) << FRAC_BITS;

	// reciprocal multipliers
	// degrees: floor(h180 / 3141), exact for 21-bit operands
	localparam logic [21:0] K_DEG     = 22'd2734778;
	localparam int          DEG_SHIFT = 33;
	// angular: floor(m / 19), exact for 22-bit operands
	localparam logic [22:0] K_ANG     = 23'd7064091;
	localparam int          ANG_SHIFT = 27;
	// heading step: m * 2^16 / 50, estimate low by at most one
	localparam logic [30:0] K_HEAD     = 31'd1374389534;
	localparam int          HEAD_SHIFT = 20;
	localparam logic [5:0]  HEAD_DIV   = 6'd25;
	// position step: m * 2^16 / 50000, estimate low by at most one
	localparam logic [30:0] K_POS     = 31'd1407374883;
	localparam int          POS_SHIFT = 30;
	localparam logic [12:0] POS_DIV   = 13'd3125;

	localparam logic [SINE_W-1:0] SINE_TABLE [91] = '{
		10'd0,   10'd18,  10'd35,  10'd52,  10'd70,  10'd87,  10'd105, 10'd122,
		10'd139, 10'd156, 10'd174, 10'd191, 10'd208, 10'd225, 10'd242, 10'd259,
		10'd276, 10'd292, 10'd309, 10'd326, 10'd342, 10'd358, 10'd375, 10'd391,
		10'd407, 10'd423, 10'd438, 10'd454, 10'd470, 10'd485, 10'd500, 10'd515,
		10'd530, 10'd545, 10'd559, 10'd574, 10'd588, 10'd602, 10'd616, 10'd629,
		10'd643, 10'd656, 10'd669, 10'd682, 10'd695, 10'd707, 10'd719, 10'd731,
		10'd743, 10'd755, 10'd766, 10'd777, 10'd788, 10'd799, 10'd809, 10'd819,
		10'd829, 10'd839, 10'd848, 10'd857, 10'd866, 10'd875, 10'd883, 10'd891,
		10'd899, 10'd906, 10'd914, 10'd921, 10'd927, 10'd934, 10'd940, 10'd946,
		10'd951, 10'd956, 10'd961, 10'd966, 10'd970, 10'd974, 10'd978, 10'd982,
		10'd985, 10'd988, 10'd990, 10'd993, 10'd995, 10'd996, 10'd998, 10'd999,
		10'd999, 10'd1000, 10'd1000
	};

	function automatic logic [SINE_W-1:0] sine_lookup(input logic [TRIG_IDX_W-1:0] idx);
		logic [SINE_W-1:0] val;
		val = '0;
		if (idx <= TRIG_IDX_W'(90)) begin
			val = SINE_TABLE[idx];
		end
		return val;
	endfunction

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_DIVIDE,
		ST_PRODUCT,
		ST_QUOTIENT,
		ST_REMAINDER,
		ST_ADVANCE,
		ST_PUBLISH
	} ddo_state_t;

	typedef struct packed {
		logic cfg_write;
		logic load;
		logic scale;
		logic divide;
		logic product;
		logic quotient;
		logic remainder;
		logic advance;
		logic publish;
	} ddo_cmd_t;

endpackage

>>> src/ddo_ctrl.sv
// ----------------------------------------------------------------------------
// Odometry controller
// Steps one request through the datapath and owns the channel handshakes.
// ----------------------------------------------------------------------------
module ddo_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	output ddo_pkg::ddo_cmd_t cmd
);
	import ddo_pkg::*;

	ddo_state_t state_q, state_d;
	logic       out_valid_q, out_valid_d;
	logic       out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.cfg_write = cfg_valid;
		in_stall      = (state_q != ST_IDLE);
		out_free      = !out_valid_q || !out_stall;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCALE;
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				cmd.divide = 1'b1;
				state_d    = ST_PRODUCT;
			end
			ST_PRODUCT: begin
				cmd.product = 1'b1;
				state_d     = ST_QUOTIENT;
			end
			ST_QUOTIENT: begin
				cmd.quotient = 1'b1;
				state_d      = ST_REMAINDER;
			end
			ST_REMAINDER: begin
				cmd.remainder = 1'b1;
				state_d       = ST_ADVANCE;
			end
			ST_ADVANCE: begin
				cmd.advance = 1'b1;
				state_d     = ST_PUBLISH;
			end
			ST_PUBLISH: begin
				if (out_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (cmd.publish) begin
			out_valid_d = 1'b1;
		end else if (out_stall) begin
			out_valid_d = out_valid_q;
		end else begin
			out_valid_d = 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

endmodule

>>> src/ddo_datapath.sv
// ----------------------------------------------------------------------------
// Odometry datapath
// Velocities, reciprocal divides, sine lookup, pose registers and the
// result register, each step loaded on its controller command.
// ----------------------------------------------------------------------------
module ddo_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ddo_pkg::ddo_cmd_t                   cmd,
	input  logic [ddo_pkg::COUNT_W-1:0]         noise_threshold,
	input  logic [ddo_pkg::COUNT_W-1:0]         left_count,
	input  logic [ddo_pkg::COUNT_W-1:0]         right_count,
	input  logic                                left_reverse,
	input  logic                                right_reverse,
	output logic signed [ddo_pkg::LIN_W-1:0]    linear_velocity,
	output logic signed [ddo_pkg::ANG_W-1:0]    angular_velocity,
	output logic signed [ddo_pkg::INT_W-1:0]    x_integer,
	output logic signed [ddo_pkg::INT_W-1:0]    y_integer,
	output logic [ddo_pkg::HEAD_INT_W-1:0]      heading_integer
);
	import ddo_pkg::*;

	// pose and configuration
	logic [COUNT_W-1:0]       threshold_q;
	logic [POSITION_BITS-1:0] x_q, y_q;
	logic [HEADING_W-1:0]     heading_q;

	// step registers
	logic signed [COUNT_W+1:0] sum_s1, diff_s1;
	logic [20:0]               hint180_s1;
	logic signed [LIN_W-1:0]   lin_s2;
	logic [21:0]               amag_s2;
	logic                      angneg_s2;
	logic [DEG_W-1:0]          deg_s2;
	logic [17:0]               angmag_s3;
	logic signed [ANG_W-1:0]   ang_s3;
	logic [SINE_W-1:0]         cosmag_s3, sinmag_s3;
	logic [LIN_W-2:0]          linmag_s3;
	logic                      xneg_s3, yneg_s3;
	logic [24:0]               px_s4, py_s4;
	logic [HEADING_W-1:0]      qh0_s4;
	logic [25:0]               qx0_s5, qy0_s5;
	logic [5:0]                remh_s5;
	logic [12:0]               remx_s6, remy_s6;
	logic signed [HSUM_W-1:0]  hsum_s6;
	logic signed [HSUM_W-1:0]  hsub_s7;

	// result register
	logic signed [LIN_W-1:0] lin_out_q;
	logic signed [ANG_W-1:0] ang_out_q;
	logic [INT_W-1:0]        x_out_q, y_out_q;
	logic [HEAD_INT_W-1:0]   head_out_q;

	// load
	logic [COUNT_W-1:0]      lc_c, rc_c;
	logic signed [COUNT_W:0] l_c, r_c;
	logic [20:0]             hint180_c;

	assign lc_c = (left_count > threshold_q) ? left_count : '0;
	assign rc_c = (right_count > threshold_q) ? right_count : '0;
	assign l_c  = left_reverse ? -$signed({1'b0, lc_c}) : $signed({1'b0, lc_c});
	assign r_c  = right_reverse ? -$signed({1'b0, rc_c}) : $signed({1'b0, rc_c});
	assign hint180_c = 21'(heading_q[HEADING_W-1:FRAC_BITS]) * 21'd180;

	// scale
	logic signed [LIN_W:0] sum_ext_c, p15_c, p15_adj_c;
	logic [COUNT_W:0]      dmag_c;
	logic [21:0]           amag_c;
	logic [42:0]           degprod_c;

	assign sum_ext_c = {{(LIN_W - COUNT_W - 1){sum_s1[COUNT_W+1]}}, sum_s1};
	assign p15_c     = (sum_ext_c <<< 4) - sum_ext_c;
	assign p15_adj_c = p15_c + $signed({{LIN_W{1'b0}}, p15_c[LIN_W]});
	assign dmag_c    = diff_s1[COUNT_W+1] ? (COUNT_W+1)'(-diff_s1) : (COUNT_W+1)'(diff_s1);
	assign amag_c    = 22'(dmag_c) * 22'd1000;
	assign degprod_c = 43'(hint180_s1) * 43'(K_DEG);

	// divide
	logic [44:0]           angprod_c;
	logic [17:0]           angmag_c;
	logic [DEG_W-1:0]      degf_c;
	logic                  cneg_c, sneg_c;
	logic [TRIG_IDX_W-1:0] sidx_c;

	assign angprod_c = 45'(amag_s2) * 45'(K_ANG);
	assign angmag_c  = angprod_c[ANG_SHIFT+17:ANG_SHIFT];
	assign sidx_c    = degf_c[TRIG_IDX_W-1:0];

	always_comb begin
		degf_c = deg_s2;
		cneg_c = 1'b0;
		sneg_c = 1'b0;
		if (deg_s2 > 9'd90 && deg_s2 <= 9'd180) begin
			degf_c = 9'd180 - deg_s2;
			cneg_c = 1'b1;
		end else if (deg_s2 > 9'd180 && deg_s2 <= 9'd270) begin
			degf_c = deg_s2 - 9'd180;
			cneg_c = 1'b1;
			sneg_c = 1'b1;
		end else if (deg_s2 > 9'd270) begin
			degf_c = 9'd360 - deg_s2;
			sneg_c = 1'b1;
		end
	end

	// product and quotient
	logic [48:0] hprod_c;
	logic [55:0] xprod_c, yprod_c;

	assign hprod_c = 49'(angmag_s3) * 49'(K_HEAD);
	assign xprod_c = 56'(px_s4) * 56'(K_POS);
	assign yprod_c = 56'(py_s4) * 56'(K_POS);

	// remainder and advance
	logic [HEADING_W-1:0]     dh_c;
	logic signed [HSUM_W-1:0] dh_sgn_c;
	logic [25:0]              dx_c, dy_c;
	logic signed [HSUM_W-1:0] hfull_c, hfin_c;
	logic [POSITION_BITS-1:0] xr_c, yr_c;

	assign dh_c     = qh0_s4 + HEADING_W'(remh_s5 >= HEAD_DIV);
	assign dh_sgn_c = angneg_s2 ? -$signed({2'b00, dh_c}) : $signed({2'b00, dh_c});
	assign dx_c     = qx0_s5 + 26'(remx_s6 >= POS_DIV);
	assign dy_c     = qy0_s5 + 26'(remy_s6 >= POS_DIV);
	assign hfull_c  = $signed({2'b00, HEADING_FULL});
	assign hfin_c   = hsub_s7[HSUM_W-1] ? hsub_s7 + hfull_c : hsub_s7;
	assign xr_c = x_q + {{(POSITION_BITS - FRAC_BITS){1'b0}}, {FRAC_BITS{x_q[POSITION_BITS-1]}}};
	assign yr_c = y_q + {{(POSITION_BITS - FRAC_BITS){1'b0}}, {FRAC_BITS{y_q[POSITION_BITS-1]}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= COUNT_W'(2);
			x_q         <= '0;
			y_q         <= '0;
			heading_q   <= '0;
		end else begin
			if (cmd.cfg_write) begin
				threshold_q <= noise_threshold;
			end
			if (cmd.advance) begin
				x_q <= xneg_s3 ? x_q - POSITION_BITS'(dx_c) : x_q + POSITION_BITS'(dx_c);
				y_q <= yneg_s3 ? y_q - POSITION_BITS'(dy_c) : y_q + POSITION_BITS'(dy_c);
			end
			if (cmd.publish) begin
				heading_q <= hfin_c[HEADING_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum_s1     <= {l_c[COUNT_W], l_c} + {r_c[COUNT_W], r_c};
			diff_s1    <= {r_c[COUNT_W], r_c} - {l_c[COUNT_W], l_c};
			hint180_s1 <= hint180_c;
		end
		if (cmd.scale) begin
			lin_s2    <= p15_adj_c[LIN_W:1];
			amag_s2   <= amag_c;
			angneg_s2 <= diff_s1[COUNT_W+1];
			deg_s2    <= degprod_c[DEG_SHIFT+DEG_W-1:DEG_SHIFT];
		end
		if (cmd.divide) begin
			angmag_s3 <= angmag_c;
			ang_s3    <= angneg_s2 ? -$signed({1'b0, angmag_c}) : $signed({1'b0, angmag_c});
			cosmag_s3 <= sine_lookup(TRIG_IDX_W'(90) - sidx_c);
			sinmag_s3 <= sine_lookup(sidx_c);
			linmag_s3 <= lin_s2[LIN_W-1] ? (LIN_W-1)'(-lin_s2) : (LIN_W-1)'(lin_s2);
			xneg_s3   <= lin_s2[LIN_W-1] ^ cneg_c;
			yneg_s3   <= lin_s2[LIN_W-1] ^ sneg_c;
		end
		if (cmd.product) begin
			px_s4  <= 25'(linmag_s3) * 25'(cosmag_s3);
			py_s4  <= 25'(linmag_s3) * 25'(sinmag_s3);
			qh0_s4 <= hprod_c[HEAD_SHIFT+HEADING_W-1:HEAD_SHIFT];
		end
		if (cmd.quotient) begin
			qx0_s5  <= xprod_c[POS_SHIFT+25:POS_SHIFT];
			qy0_s5  <= yprod_c[POS_SHIFT+25:POS_SHIFT];
			remh_s5 <= 6'((33'(angmag_s3) << 15) - 33'(qh0_s4) * 33'd25);
		end
		if (cmd.remainder) begin
			remx_s6 <= 13'((37'(px_s4) << 12) - 37'(qx0_s5) * 37'd3125);
			remy_s6 <= 13'((37'(py_s4) << 12) - 37'(qy0_s5) * 37'd3125);
			hsum_s6 <= $signed({2'b00, heading_q}) + dh_sgn_c;
		end
		if (cmd.advance) begin
			hsub_s7 <= (hsum_s6 > hfull_c) ? hsum_s6 - hfull_c : hsum_s6;
		end
		if (cmd.publish) begin
			lin_out_q  <= lin_s2;
			ang_out_q  <= ang_s3;
			x_out_q    <= xr_c[FRAC_BITS+INT_W-1:FRAC_BITS];
			y_out_q    <= yr_c[FRAC_BITS+INT_W-1:FRAC_BITS];
			head_out_q <= hfin_c[HEADING_W-1:FRAC_BITS];
		end
	end

	assign linear_velocity  = lin_out_q;
	assign angular_velocity = ang_out_q;
	assign x_integer        = $signed(x_out_q);
	assign y_integer        = $signed(y_out_q);
	assign heading_integer  = head_out_q;

endmodule

>>> src/differential_drive_odometry_unit.sv
// ----------------------------------------------------------------------------
// Differential drive odometry unit
// Wheel count odometry: velocities and integrated pose, one request per period.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry the two wheel counts and direction
// bits of one sample period; a request is taken when in_valid is high and
// in_stall is low. Output channel: out_valid / out_stall carry the linear and
// angular velocity and the integer pose after that request.
// The user must write the noise threshold through cfg_valid / cfg_ready /
// noise_threshold only while the unit is idle; the unit does not enforce this,
// and cfg_ready is always high. The controller steps each accepted request
// through scale, divide, product, quotient, remainder, advance and publish;
// out_valid rises with publish, and no new request is taken before it.
// When the receiver stalls, the finished result holds in the output register
// and the last step waits there; the next request is taken once it moves on.
// Reset clears the pose to zero, the heading to zero, the threshold to 2 and
// drops any request in flight.
// ----------------------------------------------------------------------------
`include "differential_drive_odometry_unit_defines.svh"

module differential_drive_odometry_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ddo_pkg::COUNT_W-1:0]         left_count,
	input  logic [ddo_pkg::COUNT_W-1:0]         right_count,
	input  logic                                left_reverse,
	input  logic                                right_reverse,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ddo_pkg::LIN_W-1:0]    linear_velocity,
	output logic signed [ddo_pkg::ANG_W-1:0]    angular_velocity,
	output logic signed [ddo_pkg::INT_W-1:0]    x_integer,
	output logic signed [ddo_pkg::INT_W-1:0]    y_integer,
	output logic [ddo_pkg::HEAD_INT_W-1:0]      heading_integer,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ddo_pkg::COUNT_W-1:0]         noise_threshold
);
	import ddo_pkg::*;

	ddo_cmd_t cmd;

	ddo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	ddo_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.noise_threshold  (noise_threshold),
		.left_count       (left_count),
		.right_count      (right_count),
		.left_reverse     (left_reverse),
		.right_reverse    (right_reverse),
		.linear_velocity  (linear_velocity),
		.angular_velocity (angular_velocity),
		.x_integer        (x_integer),
		.y_integer        (y_integer),
		.heading_integer  (heading_integer)
	);

	// one request in flight at a time
	`DDO_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// heading always wrapped into one turn
	`DDO_ASSERT_IMPLY(a_heading_range, clk, arst_n, out_valid, heading_integer <= 13'd6283)
	// fixed latency when the output register is free
	`DDO_ASSERT_IMPLY(a_latency, clk, arst_n, in_valid && !in_stall && !out_valid, ##8 out_valid)

endmodule
